// ===== hdl/atrp_pkg.sv =====
// Shared constants for the modem reply parser: line store geometry,
// character codes and status codes. No dependencies.
package atrp_pkg;

    // Line store geometry.
    localparam int LINE_CHARS = 64;
    localparam int MAX_LINES  = 16;

    // Counter widths hold the limits themselves.
    localparam int LEN_W = $clog2(LINE_CHARS + 1);
    localparam int CNT_W = $clog2(MAX_LINES + 1);

    // Port widths of the result item.
    localparam int STATUS_W = 2;
    localparam int LINE_W   = 4;
    localparam int COL_W    = 6;
    localparam int HELD_W   = 5;

    // Character codes.
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TILDE = 8'h7E;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_E     = 8'h45;
    localparam logic [7:0] CHR_K     = 8'h4B;
    localparam logic [7:0] CHR_O     = 8'h4F;
    localparam logic [7:0] CHR_R     = 8'h52;

    // Status codes.
    localparam logic [STATUS_W-1:0] STS_BUSY  = 2'd0;
    localparam logic [STATUS_W-1:0] STS_READY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_ERROR = 2'd2;

endpackage

// ===== hdl/at_response_parser.sv =====
// Modem reply parser: top level with input register, grammar logic and
// result register. Depends on atrp_pkg.
//
// Usage
//   Input channel: one received byte per item on i_ch, qualified by
//   i_valid and held off by o_stall. Result channel: one result item per
//   input item on the o_ fields, qualified by o_valid and held off by
//   i_stall.
//   Every byte gives a status (in progress, reply complete, syntax error),
//   the final OK flag, an optional write strobe for the external line store
//   (line, column, character), a line close strobe, a clear request after
//   an error, and the number of lines now held.
//   The result of a byte is registered: the byte waits in the input register,
//   and the parser logic fills the result register when it takes the byte.
//   One byte is taken every cycle while the receiver does not stall; each byte updates the parser state.
//   Reset puts the parser in the wait-for-CR state, clears the OK flag and
//   the counts, and empties both registers.
//   While the receiver stalls, the result register holds its item; the
//   input register still takes one more byte, after which o_stall rises
//   until the result is taken.
module at_response_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_ch,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [atrp_pkg::STATUS_W-1:0] o_status,
    output logic                          o_reply_ok,
    output logic                          o_char_valid,
    output logic [atrp_pkg::LINE_W-1:0]   o_char_line,
    output logic [atrp_pkg::COL_W-1:0]    o_char_col,
    output logic [7:0]                    o_char_value,
    output logic                          o_line_close,
    output logic                          o_store_clear,
    output logic [atrp_pkg::HELD_W-1:0]   o_lines_held
);
    import atrp_pkg::*;

    typedef enum logic [4:0] {
        S_WAIT_CR    = 5'd0,
        S_WAIT_LF    = 5'd1,
        S_FIRST      = 5'd2,
        S_GOT_O      = 5'd3,
        S_OK_CR      = 5'd4,
        S_OK_LF      = 5'd5,
        S_GOT_E      = 5'd6,
        S_GOT_ER     = 5'd7,
        S_GOT_ERR    = 5'd8,
        S_GOT_ERRO   = 5'd9,
        S_ERR_CR     = 5'd10,
        S_ERR_LF     = 5'd11,
        S_PLUS       = 5'd12,
        S_TEXT       = 5'd13,
        S_TEXT_LF    = 5'd14,
        S_NEXT       = 5'd15,
        S_NEXT_LF    = 5'd16,
        S_NEXT_CODE  = 5'd17
    } t_state;

    // Parser state.
    t_state             r_state, n_state;
    logic               r_ok, n_ok;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [LEN_W-1:0]   r_len, n_len;

    // Input register.
    logic               r_in_valid;
    logic [7:0]         r_ch;

    // Result register.
    logic               r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic               r_reply_ok;
    logic               r_char_valid;
    logic [LINE_W-1:0]  r_char_line;
    logic [COL_W-1:0]   r_char_col;
    logic [7:0]         r_char_value;
    logic               r_line_close;
    logic               r_store_clear;
    logic [HELD_W-1:0]  r_lines_held;

    logic out_free, in_take, in_load;
    logic printable, do_put, do_end, done, err, put_ok, close_ok;

    assign out_free = !r_out_valid || !i_stall;
    assign in_take  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_load  = i_valid && !o_stall;

    assign printable = (r_ch >= CHR_SPACE) && (r_ch <= CHR_TILDE);

    always_comb begin
        n_state = r_state;
        n_ok    = r_ok;
        do_put  = 1'b0;
        do_end  = 1'b0;
        done    = 1'b0;
        err     = 1'b0;
        unique case (r_state)
            S_WAIT_CR: begin
                if (r_ch == CHR_CR) n_state = S_WAIT_LF; else err = 1'b1;
            end
            S_WAIT_LF: begin
                if (r_ch == CHR_LF) n_state = S_FIRST; else err = 1'b1;
            end
            S_FIRST: begin
                if (r_ch == CHR_O) begin
                    n_state = S_GOT_O;
                end else if (r_ch == CHR_E) begin
                    n_state = S_GOT_E;
                end else if (r_ch == CHR_PLUS) begin
                    do_put  = 1'b1;
                    n_state = S_PLUS;
                end else begin
                    err = 1'b1;
                end
            end
            S_GOT_O: begin
                if (r_ch == CHR_K) begin
                    n_ok    = 1'b1;
                    n_state = S_OK_CR;
                end else begin
                    err = 1'b1;
                end
            end
            S_OK_CR: begin
                if (r_ch == CHR_CR) n_state = S_OK_LF; else err = 1'b1;
            end
            S_OK_LF, S_ERR_LF: begin
                if (r_ch == CHR_LF) begin
                    do_end  = 1'b1;
                    done    = 1'b1;
                    n_state = S_WAIT_CR;
                end else begin
                    err = 1'b1;
                end
            end
            S_GOT_E: begin
                if (r_ch == CHR_R) n_state = S_GOT_ER; else err = 1'b1;
            end
            S_GOT_ER: begin
                if (r_ch == CHR_R) n_state = S_GOT_ERR; else err = 1'b1;
            end
            S_GOT_ERR: begin
                if (r_ch == CHR_O) n_state = S_GOT_ERRO; else err = 1'b1;
            end
            S_GOT_ERRO: begin
                if (r_ch == CHR_R) begin
                    n_ok    = 1'b0;
                    n_state = S_ERR_CR;
                end else begin
                    err = 1'b1;
                end
            end
            S_ERR_CR: begin
                if (r_ch == CHR_CR) n_state = S_ERR_LF; else err = 1'b1;
            end
            S_PLUS: begin
                if (printable) begin
                    do_put  = 1'b1;
                    n_state = S_TEXT;
                end else begin
                    err = 1'b1;
                end
            end
            S_TEXT: begin
                if (printable) begin
                    do_put = 1'b1;
                end else if (r_ch == CHR_CR) begin
                    n_state = S_TEXT_LF;
                end else begin
                    err = 1'b1;
                end
            end
            S_TEXT_LF: begin
                if (r_ch == CHR_LF) begin
                    do_end  = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    err = 1'b1;
                end
            end
            S_NEXT: begin
                if (r_ch == CHR_CR) begin
                    n_state = S_NEXT_LF;
                end else if (r_ch == CHR_PLUS) begin
                    do_put  = 1'b1;
                    n_state = S_PLUS;
                end else begin
                    err = 1'b1;
                end
            end
            S_NEXT_LF: begin
                if (r_ch == CHR_LF) n_state = S_NEXT_CODE; else err = 1'b1;
            end
            S_NEXT_CODE: begin
                if (r_ch == CHR_E) begin
                    n_state = S_GOT_E;
                end else if (r_ch == CHR_O) begin
                    n_state = S_GOT_O;
                end else begin
                    err = 1'b1;
                end
            end
            default: err = 1'b1;
        endcase

        // Writes beyond the line size or the line count are dropped.
        put_ok   = do_put && !err && (r_len < LEN_W'(LINE_CHARS))
                   && (r_cnt < CNT_W'(MAX_LINES));
        close_ok = do_end && !err && (r_cnt < CNT_W'(MAX_LINES));

        if (err) begin
            n_state = S_WAIT_CR;
            n_cnt   = '0;
            n_len   = '0;
        end else begin
            n_cnt = close_ok ? r_cnt + CNT_W'(1) : r_cnt;
            if (do_end) begin
                n_len = '0;
            end else if (put_ok) begin
                n_len = r_len + LEN_W'(1);
            end else begin
                n_len = r_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WAIT_CR;
            r_ok        <= 1'b0;
            r_cnt       <= '0;
            r_len       <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (in_take) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (in_take) begin
                r_state <= n_state;
                r_ok    <= n_ok;
                r_cnt   <= n_cnt;
                r_len   <= n_len;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_ch <= i_ch;
        end
        if (in_take) begin
            if (err) begin
                r_status <= STS_ERROR;
            end else if (done) begin
                r_status <= STS_READY;
            end else begin
                r_status <= STS_BUSY;
            end
            r_reply_ok    <= n_ok;
            r_char_valid  <= put_ok;
            r_char_line   <= put_ok ? LINE_W'(r_cnt) : '0;
            r_char_col    <= put_ok ? COL_W'(r_len) : '0;
            r_char_value  <= put_ok ? r_ch : 8'd0;
            r_line_close  <= close_ok;
            r_store_clear <= err;
            r_lines_held  <= HELD_W'(n_cnt);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_reply_ok    = r_reply_ok;
    assign o_char_valid  = r_char_valid;
    assign o_char_line   = r_char_line;
    assign o_char_col    = r_char_col;
    assign o_char_value  = r_char_value;
    assign o_line_close  = r_line_close;
    assign o_store_clear = r_store_clear;
    assign o_lines_held  = r_lines_held;

endmodule
